FILE: sv/lhc_pkg.sv
// ----------------------------------------------------------------------------
// lhc_pkg: shared types and constants for the handle cache
// Port widths, parameter defaults and the control word driven into each cell.
// ----------------------------------------------------------------------------
`default_nettype none

package lhc_pkg;

  localparam int unsigned EntriesDef  = 64;
  localparam int unsigned KeyWidthDef = 16;

  localparam int unsigned TileKeyW  = 16;
  localparam int unsigned SlotW     = 6;
  localparam int unsigned OccW      = 7;
  localparam int unsigned CapW      = 7;
  localparam logic [CapW-1:0] CapReset = 7'd64;

  // Control word shared by every cell of the row.
  typedef struct packed {
    logic cmp;  // capture compare results against the probe key
    logic upd;  // apply the update decided in the update state
    logic hit;  // the update is a hit (otherwise a miss insert)
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: sv/lhc_cell.sv
// ----------------------------------------------------------------------------
// lhc_cell: one entry of the handle cache
// Holds valid, key and recency rank of one slot, compares the probe key,
// flags a victim, and on an update ages or refreshes its rank or loads a key.
// ----------------------------------------------------------------------------
`default_nettype none

module lhc_cell #(
  parameter int unsigned KEY_W  = lhc_pkg::KeyWidthDef,
  parameter int unsigned RANK_W = 6
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire lhc_pkg::cell_ctl_t  ctl,
  input  wire  [KEY_W-1:0]         probe_key,
  input  wire  [RANK_W-1:0]        victim_rank,
  input  wire  [RANK_W-1:0]        hit_rank,
  input  wire                      tgt,
  input  wire  [KEY_W-1:0]         new_key,
  output logic                     valid,
  output logic [KEY_W-1:0]         key,
  output logic [RANK_W-1:0]        rank,
  output logic                     match,
  output logic                     victim
);

  logic              valid_r, valid_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic              match_r, match_nxt;
  logic              victim_r, victim_nxt;

  always_comb begin
    valid_nxt  = valid_r;
    key_nxt    = key_r;
    rank_nxt   = rank_r;
    match_nxt  = match_r;
    victim_nxt = victim_r;
    if (ctl.cmp) begin
      match_nxt  = valid_r && (key_r == probe_key);
      // Ranks form a permutation, so the oldest entry holds rank count-1.
      victim_nxt = valid_r && (rank_r == victim_rank);
    end
    if (ctl.upd) begin
      if (ctl.hit) begin
        if (match_r) begin
          rank_nxt = '0;
        end else if (valid_r && (rank_r < hit_rank)) begin
          rank_nxt = rank_r + 1'b1;
        end
      end else begin
        if (tgt) begin
          valid_nxt = 1'b1;
          key_nxt   = new_key;
          rank_nxt  = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      rank_r   <= '0;
      match_r  <= 1'b0;
      victim_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      rank_r   <= rank_nxt;
      match_r  <= match_nxt;
      victim_r <= victim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign valid  = valid_r;
  assign key    = key_r;
  assign rank   = rank_r;
  assign match  = match_r;
  assign victim = victim_r;

endmodule

`default_nettype wire

FILE: sv/lru_handle_cache.sv
// ----------------------------------------------------------------------------
// lru_handle_cache: fully associative handle cache with true LRU replacement
// A row of entry cells keeps key, valid and recency rank; the top level
// decides hit, victim or free slot and drives one update per request.
// ----------------------------------------------------------------------------
//
//   channel  | signals                                  | direction
//   ---------+------------------------------------------+----------
//   in       | in_valid, in_stall, in_tile_key          | request
//   out      | out_valid, out_stall, out_hit, out_slot, | result
//            | out_evicted, out_evicted_key,            |
//            | out_occupancy                            |
//   cfg      | cfg_we, cfg_data (capacity)              | write only
//
// Each request passes the transfer and then the update state: the transfer
// registers the key compare and the victim search in every cell, the update
// state updates the ranks and loads the result register. The update waits
// while a previous result is still stalled on the output. Reset empties the
// cache at once and sets the capacity to 64. in_stall is high from a transfer
// until its update is done.
`default_nettype none

module lru_handle_cache #(
  parameter int unsigned ENTRIES   = lhc_pkg::EntriesDef,
  parameter int unsigned KEY_WIDTH = lhc_pkg::KeyWidthDef
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [lhc_pkg::TileKeyW-1:0] in_tile_key,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         out_hit,
  output logic [lhc_pkg::SlotW-1:0]    out_slot,
  output logic                         out_evicted,
  output logic [lhc_pkg::TileKeyW-1:0] out_evicted_key,
  output logic [lhc_pkg::OccW-1:0]     out_occupancy,
  input  wire                          cfg_we,
  input  wire  [lhc_pkg::CapW-1:0]     cfg_data
);

  localparam int unsigned RankW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW  = (CntW > lhc_pkg::CapW) ? CntW : lhc_pkg::CapW;
  localparam int unsigned TkW   = lhc_pkg::TileKeyW;
  localparam int unsigned SlotW = lhc_pkg::SlotW;
  localparam int unsigned OccW  = lhc_pkg::OccW;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic                    state_r, state_nxt;
  logic [KEY_WIDTH-1:0]    key_r, key_nxt;
  logic [CntW-1:0]         count_r, count_nxt;
  logic [lhc_pkg::CapW-1:0] cap_r, cap_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    hit_r, hit_nxt;
  logic [SlotW-1:0]        slot_r, slot_nxt;
  logic                    evicted_r, evicted_nxt;
  logic [TkW-1:0]          evkey_r, evkey_nxt;
  logic [OccW-1:0]         occ_r, occ_nxt;

  lhc_pkg::cell_ctl_t      ctl;
  logic                    in_xfer, go;

  logic [KEY_WIDTH-1:0]    probe_key;
  logic [KEY_WIDTH+TkW-1:0] probe_ext;
  logic [RankW-1:0]        victim_rank;
  logic [CntW-1:0]         count_m1;
  logic [CntW+RankW-1:0]   count_m1_ext;

  logic [ENTRIES-1:0]      valid_v, match_v, victim_v, free_oh, target_oh, tgt_v;
  logic [KEY_WIDTH-1:0]    cell_key  [ENTRIES];
  logic [RankW-1:0]        cell_rank [ENTRIES];

  logic                    any_hit, do_evict;
  logic [RankW-1:0]        hit_rank;
  logic [KEY_WIDTH-1:0]    victim_key;
  logic [RankW-1:0]        hit_idx, tgt_idx;
  logic [CmpW-1:0]         cap_ext, cap_eff, count_ext;
  logic [RankW+SlotW-1:0]  slot_ext;
  logic [KEY_WIDTH+TkW-1:0] evkey_ext;
  logic [CntW+OccW-1:0]    occ_ext;

  // Probe key and victim rank, resized to the internal widths.
  assign probe_ext    = {{KEY_WIDTH{1'b0}}, in_tile_key};
  assign probe_key    = probe_ext[KEY_WIDTH-1:0];
  assign count_m1     = count_r - 1'b1;
  assign count_m1_ext = {{RankW{1'b0}}, count_m1};
  assign victim_rank  = count_m1_ext[RankW-1:0];

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign go       = (state_r == ST_UPD) && (!out_valid_r || !out_stall);

  always_comb begin
    ctl.cmp = in_xfer;
    ctl.upd = go;
    ctl.hit = any_hit;
  end

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      lhc_cell #(
        .KEY_W  (KEY_WIDTH),
        .RANK_W (RankW)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .probe_key   (probe_key),
        .victim_rank (victim_rank),
        .hit_rank    (hit_rank),
        .tgt         (tgt_v[gi]),
        .new_key     (key_r),
        .valid       (valid_v[gi]),
        .key         (cell_key[gi]),
        .rank        (cell_rank[gi]),
        .match       (match_v[gi]),
        .victim      (victim_v[gi])
      );
    end
  endgenerate

  // Lowest free slot as a one-hot word: the lowest zero of the valid vector.
  assign free_oh = ~valid_v & (valid_v + 1'b1);

  always_comb begin
    cap_ext   = {{(CmpW - lhc_pkg::CapW){1'b0}}, cap_r};
    count_ext = {{(CmpW - CntW){1'b0}}, count_r};
    if (cap_ext == '0) begin
      cap_eff = CmpW'(1);
    end else if (cap_ext > CmpW'(ENTRIES)) begin
      cap_eff = CmpW'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  always_comb begin
    any_hit    = |match_v;
    do_evict   = !any_hit && (count_ext >= cap_eff);
    target_oh  = do_evict ? victim_v : free_oh;
    tgt_v      = any_hit ? '0 : target_oh;
    hit_rank   = '0;
    victim_key = '0;
    hit_idx    = '0;
    tgt_idx    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_v[i]) begin
        hit_rank = hit_rank | cell_rank[i];
        hit_idx  = hit_idx | RankW'(i);
      end
      if (victim_v[i]) begin
        victim_key = victim_key | cell_key[i];
      end
      if (target_oh[i]) begin
        tgt_idx = tgt_idx | RankW'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    cap_nxt       = cap_r;
    out_valid_nxt = out_valid_r;
    hit_nxt       = hit_r;
    slot_nxt      = slot_r;
    evicted_nxt   = evicted_r;
    evkey_nxt     = evkey_r;
    occ_nxt       = occ_r;
    slot_ext      = '0;
    evkey_ext     = '0;
    occ_ext       = '0;

    if (cfg_we) begin
      cap_nxt = cfg_data;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          key_nxt   = probe_key;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (go) begin
          // An eviction frees one slot and refills it, so the count holds.
          if (!any_hit && !do_evict) begin
            count_nxt = count_r + 1'b1;
          end
          slot_ext      = {{SlotW{1'b0}}, (any_hit ? hit_idx : tgt_idx)};
          evkey_ext     = {{TkW{1'b0}}, (do_evict ? victim_key : {KEY_WIDTH{1'b0}})};
          occ_ext       = {{OccW{1'b0}}, count_nxt};
          out_valid_nxt = 1'b1;
          hit_nxt       = any_hit;
          slot_nxt      = slot_ext[SlotW-1:0];
          evicted_nxt   = do_evict;
          evkey_nxt     = evkey_ext[TkW-1:0];
          occ_nxt       = occ_ext[OccW-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= lhc_pkg::CapReset;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    hit_r     <= hit_nxt;
    slot_r    <= slot_nxt;
    evicted_r <= evicted_nxt;
    evkey_r   <= evkey_nxt;
    occ_r     <= occ_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = hit_r;
  assign out_slot        = slot_r;
  assign out_evicted     = evicted_r;
  assign out_evicted_key = evkey_r;
  assign out_occupancy   = occ_r;

endmodule

`default_nettype wire

FILE: test/tb_lru_handle_cache.sv
// ----------------------------------------------------------------------------
// tb_lru_handle_cache: self-checking bench for the LRU handle cache
// Drives tile keys through the request channel with random gaps, stalls the
// result channel at random, and compares every result field with an LRU
// cache model kept in the bench. Capacity is rewritten between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lru_handle_cache;

  import lhc_pkg::*;

  localparam int unsigned EntryCount  = EntriesDef;
  localparam int unsigned KeyW        = KeyWidthDef;
  localparam int unsigned MaxWait     = 18;
  localparam int unsigned RandomItems = 1200;
  localparam int unsigned CycleLimit  = 500000;

  typedef struct packed {
    logic                hit;
    logic [SlotW-1:0]    slot;
    logic                evicted;
    logic [TileKeyW-1:0] evicted_key;
    logic [OccW-1:0]     occupancy;
  } lookup_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [TileKeyW-1:0] in_tile_key = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_hit;
  logic [SlotW-1:0]    out_slot;
  logic                out_evicted;
  logic [TileKeyW-1:0] out_evicted_key;
  logic [OccW-1:0]     out_occupancy;
  logic                cfg_we = 1'b0;
  logic [CapW-1:0]     cfg_data = '0;

  lru_handle_cache uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_tile_key     (in_tile_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_slot        (out_slot),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .out_occupancy   (out_occupancy),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Cache model state.
  logic              line_used [EntryCount];
  logic [KeyW-1:0]   line_key  [EntryCount];
  logic [SlotW-1:0]  line_age  [EntryCount];
  logic [OccW-1:0]   used_lines;
  logic [CapW-1:0]   cap_reg;

  lookup_t     pending_lookups [$];
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  bit          gap_on = 1'b1;
  bit          stall_on = 1'b1;

  function automatic int unsigned eff_capacity(input logic [CapW-1:0] c);
    if (c == 0) return 1;
    if (c > EntryCount) return EntryCount;
    return c;
  endfunction

  function automatic int unsigned draw_wait(input bit on);
    if (!on) return 0;
    return $urandom_range(0, MaxWait);
  endfunction

  // Looks up one key, updates the model and returns the expected result.
  function automatic lookup_t cache_lookup(input logic [KeyW-1:0] k);
    lookup_t          r;
    int               found;
    int               oldest;
    int               target;
    logic [SlotW-1:0] age_hit;
    r = '0;
    found = -1;
    oldest = -1;
    target = -1;
    for (int i = 0; i < EntryCount; i++) begin
      if (found < 0 && line_used[i] && line_key[i] == k) found = i;
    end
    if (found >= 0) begin
      age_hit = line_age[found];
      for (int i = 0; i < EntryCount; i++) begin
        if (line_used[i] && line_age[i] < age_hit) line_age[i] = line_age[i] + 1'b1;
      end
      line_age[found] = '0;
      r.hit = 1'b1;
      r.slot = SlotW'(found);
    end else begin
      if (used_lines >= eff_capacity(cap_reg)) begin
        for (int i = 0; i < EntryCount; i++) begin
          if (line_used[i] && (oldest < 0 || line_age[i] > line_age[oldest])) oldest = i;
        end
        if (oldest >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = line_key[oldest];
          line_used[oldest] = 1'b0;
          used_lines = used_lines - 1'b1;
          target = oldest;
        end
      end
      if (target < 0) begin
        for (int i = 0; i < EntryCount; i++) begin
          if (target < 0 && !line_used[i]) target = i;
        end
      end
      if (target >= 0) begin
        for (int i = 0; i < EntryCount; i++) begin
          if (line_used[i]) line_age[i] = line_age[i] + 1'b1;
        end
        line_used[target] = 1'b1;
        line_key[target] = k;
        line_age[target] = '0;
        used_lines = used_lines + 1'b1;
        r.slot = SlotW'(target);
      end
    end
    r.occupancy = used_lines;
    return r;
  endfunction

  // Sends one key and returns at the edge where the transfer happens.
  // in_valid is lowered only before a gap or by a drain, so back-to-back keys keep it high.
  task automatic send_key(input logic [KeyW-1:0] k);
    int unsigned gap;
    lookup_t     exp_item;
    gap = draw_wait(gap_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tile_key <= k;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    exp_item = cache_lookup(k);
    pending_lookups = {pending_lookups, exp_item};
  endtask

  task automatic drain_lookups();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_lookups.size() != 0);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] value);
    drain_lookups();
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_reg = value;
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // Result side: random stall before each transfer, then compare with the oldest
  // expectation.
  initial begin
    int unsigned hold;
    lookup_t     want;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      hold = draw_wait(stall_on);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      if (pending_lookups.size() == 0) begin
        $display("%0t: result transfer with no request waiting", $time);
        errors++;
      end else begin
        want = pending_lookups.pop_front();
        check_field("hit", want.hit, out_hit);
        check_field("slot", want.slot, out_slot);
        check_field("evicted", want.evicted, out_evicted);
        check_field("evicted_key", want.evicted_key, out_evicted_key);
        check_field("occupancy", want.occupancy, out_occupancy);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_lookups.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Key extremes, then hits on them; fills four slots from the bottom.
  task automatic test_key_extremes();
    send_key(16'h0000);
    send_key(16'hFFFF);
    send_key(16'h0000);
    send_key(16'hFFFF);
    send_key(16'h5555);
    send_key(16'hAAAA);
  endtask

  // Capacity zero, capacity above the entry count and capacity below the
  // current occupancy.
  task automatic test_capacity_limits();
    write_capacity(CapW'(0));
    send_key(16'h1234);
    send_key(16'h5555);
    send_key(16'h4321);
    write_capacity(CapW'(127));
    send_key(16'h0001);
    send_key(16'h8000);
    send_key(16'h7FFF);
    write_capacity(CapW'(1));
    send_key(16'h0F0F);
    send_key(16'h0F0F);
    send_key(16'hF0F0);
  endtask

  // Back-to-back keys against a stalling receiver, then a full drain.
  task automatic test_backpressure_drain();
    write_capacity(CapW'(8));
    gap_on = 1'b0;
    stall_on = 1'b1;
    for (int n = 0; n < 40; n++) send_key(KeyW'($urandom_range(0, 15)));
    drain_lookups();
  endtask

  // Phases with a random capacity and a key pool sized around it, so that
  // hits, fills and evictions all happen; a few keys are plain random.
  task automatic test_random_traffic();
    int unsigned     sent;
    int unsigned     phase_len;
    int unsigned     pool_size;
    logic [CapW-1:0] cap;
    logic [KeyW-1:0] pool [2*EntryCount];
    sent = 0;
    while (sent < RandomItems) begin
      case ($urandom_range(0, 5))
        0: cap = CapW'(1);
        1: cap = CapW'(64);
        2: cap = CapW'(0);
        3: cap = CapW'($urandom_range(65, 127));
        default: cap = CapW'($urandom_range(1, 64));
      endcase
      write_capacity(cap);
      pool_size = $urandom_range(1, 2 * eff_capacity(cap));
      for (int i = 0; i < pool_size; i++) pool[i] = KeyW'($urandom);
      gap_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(30, 150);
      for (int n = 0; n < phase_len; n++) begin
        if ($urandom_range(0, 9) == 0) send_key(KeyW'($urandom));
        else send_key(pool[$urandom_range(0, pool_size - 1)]);
      end
      sent += phase_len;
    end
  endtask

  initial begin
    for (int i = 0; i < EntryCount; i++) begin
      line_used[i] = 1'b0;
      line_key[i] = '0;
      line_age[i] = '0;
    end
    used_lines = '0;
    cap_reg = CapReset;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_key_extremes();
    test_capacity_limits();
    test_backpressure_drain();
    test_random_traffic();

    drain_lookups();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
